// ----- sv/sbt_pkg.sv -----
// shared types, codes and response byte tables for the scsi block target
`timescale 1ns / 1ps
package sbt_pkg;

   localparam int BLOCK_BYTES_DEF = 512;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_END   = 2'd3;

   localparam logic [7:0] OPC_READY     = 8'h00;
   localparam logic [7:0] OPC_SENSE     = 8'h03;
   localparam logic [7:0] OPC_INQ       = 8'h12;
   localparam logic [7:0] OPC_FMTCAP    = 8'h23;
   localparam logic [7:0] OPC_CAP10     = 8'h25;
   localparam logic [7:0] OPC_MODE6     = 8'h1A;
   localparam logic [7:0] OPC_RD10      = 8'h28;
   localparam logic [7:0] OPC_REMOVAL   = 8'h1E;
   localparam logic [7:0] OPC_STARTSTOP = 8'h1B;
   localparam logic [7:0] OPC_WR10      = 8'h2A;

   localparam logic [3:0] KEY_ILLEGAL    = 4'd5;
   localparam logic [7:0] ASC_BAD_OPCODE = 8'h20;
   localparam logic [7:0] PAGE_SERIAL    = 8'h80;

   typedef enum logic [2:0] {
      RK_NONE, RK_SENSE, RK_INQ_STD, RK_INQ_SER, RK_FMTCAP, RK_CAP10, RK_MODE6
   } resp_kind_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [4:0]  cdb_len;
      logic [7:0]  opcode;
      logic [7:0]  cdb_flags;
      logic [31:0] cdb_word;
      logic [15:0] cdb_length_field;
      logic [15:0] xfer_len;
      logic        storage_ok;
      logic [15:0] storage_bytes;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic        has_byte;
      logic [7:0]  resp_byte;
      logic        last;
      logic        req_write;
      logic        req_read;
      logic [31:0] req_lba;
      logic [15:0] req_count;
      logic        eject_pulse;
      logic [15:0] data_len;
   } rsp_type;

   // one job from front to back; for a response stream lba holds the last lba
   typedef struct packed {
      logic          ok;
      resp_kind_type kind;
      logic          req_write;
      logic          req_read;
      logic [31:0]   lba;
      logic [15:0]   count;
      logic          eject;
      logic [15:0]   blocks;
      logic [3:0]    key;
      logic [7:0]    code;
   } job_type;

   localparam logic [7:0] INQ_IDS [28] = '{
      8'h46, 8'h6C, 8'h69, 8'h70, 8'h70, 8'h65, 8'h72, 8'h20,
      8'h4D, 8'h61, 8'h73, 8'h73, 8'h20, 8'h53, 8'h74, 8'h6F,
      8'h72, 8'h61, 8'h67, 8'h65, 8'h20, 8'h20, 8'h20, 8'h20,
      8'h30, 8'h30, 8'h30, 8'h31
   };

   function automatic logic [5:0] resp_len_f(resp_kind_type k);
      logic [5:0] n;
      unique case (k)
         RK_SENSE:   n = 6'd18;
         RK_INQ_STD: n = 6'd36;
         RK_INQ_SER: n = 6'd5;
         RK_FMTCAP:  n = 6'd12;
         RK_CAP10:   n = 6'd8;
         RK_MODE6:   n = 6'd4;
         default:    n = 6'd1;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] resp_byte_f(resp_kind_type k, logic [5:0] i,
         logic [3:0] key, logic [7:0] code, logic [31:0] lastlba, logic [31:0] blk);
      logic [7:0] b;
      b = 8'h00;
      unique case (k)
         RK_SENSE: begin
            if (i == 6'd0) b = 8'h70;
            else if (i == 6'd2) b = {4'h0, key};
            else if (i == 6'd7) b = 8'd10;
            else if (i == 6'd12) b = code;
         end
         RK_INQ_STD: begin
            if (i == 6'd1) b = 8'h80;
            else if (i == 6'd2) b = 8'h04;
            else if (i == 6'd3) b = 8'h02;
            else if (i == 6'd4) b = 8'd31;
            else if (i >= 6'd8) b = INQ_IDS[5'(i - 6'd8)];
         end
         RK_INQ_SER: begin
            if (i == 6'd1) b = 8'h80;
            else if (i == 6'd3) b = 8'h01;
            else if (i == 6'd4) b = 8'h30;
         end
         RK_FMTCAP: begin
            if (i == 6'd3) b = 8'd8;
            else if (i == 6'd4) b = lastlba[31:24];
            else if (i == 6'd5) b = lastlba[23:16];
            else if (i == 6'd6) b = lastlba[15:8];
            else if (i == 6'd7) b = lastlba[7:0];
            else if (i == 6'd8) b = 8'h02;
            else if (i == 6'd9) b = blk[23:16];
            else if (i == 6'd10) b = blk[15:8];
            else if (i == 6'd11) b = blk[7:0];
         end
         RK_CAP10: begin
            if (i == 6'd0) b = lastlba[31:24];
            else if (i == 6'd1) b = lastlba[23:16];
            else if (i == 6'd2) b = lastlba[15:8];
            else if (i == 6'd3) b = lastlba[7:0];
            else if (i == 6'd4) b = blk[31:24];
            else if (i == 6'd5) b = blk[23:16];
            else if (i == 6'd6) b = blk[15:8];
            else if (i == 6'd7) b = blk[7:0];
         end
         RK_MODE6: begin
            if (i == 6'd0) b = 8'd3;
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- sv/sbt_front.sv -----
// front end: command state, item classification and job building
`timescale 1ns / 1ps
module sbt_front
   import sbt_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req_data,
   input  logic [31:0] total_blocks,
   output job_type     job
);

   // exact reciprocal for 16-bit dividends
   localparam logic [32:0] RECIP =
      33'(((64'd1 << 32) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

   logic [7:0]  opcode_ff, opcode_in;
   logic [4:0]  clen_ff, clen_in;
   logic [7:0]  flags_ff, flags_in;
   logic [31:0] word_ff, word_in;
   logic        have_ff, have_in, rx_ff, rx_in, tx_ff, tx_in;
   logic [3:0]  key_ff, key_in;
   logic [7:0]  code_ff, code_in;
   logic [31:0] lba_ff, lba_in;
   logic [15:0] left_ff, left_in;

   logic [15:0] dividend, blocks;
   logic [48:0] prod;
   logic [7:0]  page;
   logic [15:0] cap;

   assign dividend = (req_data.cmd == CMD_WRITE) ? req_data.xfer_len : req_data.storage_bytes;
   assign prod     = 49'(dividend) * 49'(RECIP);
   assign blocks   = prod[47:32];
   assign page     = word_ff[31:24];
   assign cap      = req_data.xfer_len;

   always_comb begin
      opcode_in = opcode_ff; clen_in = clen_ff; flags_in = flags_ff; word_in = word_ff;
      have_in = have_ff; rx_in = rx_ff; tx_in = tx_ff; key_in = key_ff; code_in = code_ff;
      lba_in = lba_ff; left_in = left_ff;
      job = '0;
      job.kind = RK_NONE;
      job.key  = key_ff;
      job.code = code_ff;
      unique case (req_data.cmd)
         CMD_START: begin
            if (req_data.cdb_len == 5'd0) begin
               key_in = KEY_ILLEGAL; code_in = ASC_BAD_OPCODE;
            end else begin
               job.ok = 1'b1;
               opcode_in = req_data.opcode; clen_in = req_data.cdb_len;
               flags_in = req_data.cdb_flags; word_in = req_data.cdb_word;
               have_in = 1'b1; rx_in = 1'b0; tx_in = 1'b0;
               if (req_data.opcode == OPC_WR10 || req_data.opcode == OPC_RD10) begin
                  if (req_data.cdb_len < 5'd10) begin
                     job.ok = 1'b0;
                  end else begin
                     lba_in = req_data.cdb_word; left_in = req_data.cdb_length_field;
                  end
               end
            end
         end
         CMD_WRITE: begin
            if (!have_ff) begin
               key_in = KEY_ILLEGAL; code_in = ASC_BAD_OPCODE;
            end else if (rx_ff) begin
               job.ok = 1'b0;
            end else if (opcode_ff != OPC_WR10) begin
               key_in = KEY_ILLEGAL; code_in = ASC_BAD_OPCODE;
            end else begin
               job.ok = req_data.storage_ok; job.req_write = 1'b1;
               job.lba = lba_ff; job.count = blocks;
               lba_in = lba_ff + 32'(blocks);
               left_in = left_ff - blocks;
               if (left_in == 16'd0) rx_in = 1'b1;
            end
         end
         CMD_READ: begin
            if (!have_ff) begin
               key_in = KEY_ILLEGAL; code_in = ASC_BAD_OPCODE;
            end else if (tx_ff) begin
               job.ok = 1'b0;
            end else if (opcode_ff == OPC_RD10) begin
               job.ok = req_data.storage_ok; job.req_read = 1'b1;
               job.lba = lba_ff; job.count = left_ff; job.blocks = blocks;
               lba_in = lba_ff + 32'(blocks);
               left_in = left_ff - blocks;
               if (left_in == 16'd0) tx_in = 1'b1;
            end else begin
               job.lba = total_blocks - 32'd1;
               priority case (opcode_ff)
                  OPC_SENSE: if (cap >= 16'd18) begin
                     job.kind = RK_SENSE; key_in = 4'd0; code_in = 8'd0;
                  end
                  OPC_INQ: if (clen_ff >= 5'd5 && cap >= 16'd36) begin
                     if (!flags_ff[0]) begin
                        if (page == 8'd0) job.kind = RK_INQ_STD;
                     end else if (page == PAGE_SERIAL) begin
                        job.kind = RK_INQ_SER;
                     end
                  end
                  OPC_FMTCAP: if (cap >= 16'd12) job.kind = RK_FMTCAP;
                  OPC_CAP10:  if (cap >= 16'd8) job.kind = RK_CAP10;
                  OPC_MODE6:  if (cap >= 16'd4) job.kind = RK_MODE6;
                  default: begin
                     key_in = KEY_ILLEGAL; code_in = ASC_BAD_OPCODE;
                  end
               endcase
               if (job.kind != RK_NONE) begin
                  job.ok = 1'b1; tx_in = 1'b1;
               end else begin
                  job.lba = 32'd0;
               end
            end
         end
         default: begin
            if (have_ff) begin
               have_in = 1'b0; clen_in = 5'd0;
               priority case (opcode_ff)
                  OPC_WR10: job.ok = rx_ff;
                  OPC_SENSE, OPC_INQ, OPC_FMTCAP, OPC_CAP10, OPC_MODE6, OPC_RD10:
                     job.ok = tx_ff;
                  OPC_READY: job.ok = 1'b1;
                  OPC_REMOVAL: job.ok = (clen_ff >= 5'd6) && (word_ff[7:0] == 8'd0);
                  OPC_STARTSTOP: if (clen_ff >= 5'd6) begin
                     job.ok = 1'b1; job.eject = word_ff[9];
                  end
                  default: begin
                     key_in = KEY_ILLEGAL; code_in = ASC_BAD_OPCODE;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opcode_ff <= '0; clen_ff <= '0; flags_ff <= '0; word_ff <= '0;
         have_ff <= 1'b0; rx_ff <= 1'b0; tx_ff <= 1'b0; key_ff <= '0; code_ff <= '0;
         lba_ff <= '0; left_ff <= '0;
      end else if (accept) begin
         opcode_ff <= opcode_in; clen_ff <= clen_in; flags_ff <= flags_in;
         word_ff <= word_in; have_ff <= have_in; rx_ff <= rx_in; tx_ff <= tx_in;
         key_ff <= key_in; code_ff <= code_in; lba_ff <= lba_in; left_ff <= left_in;
      end
   end

endmodule

// ----- sv/sbt_queue.sv -----
// two-entry job queue between front and back
`timescale 1ns / 1ps
module sbt_queue
   import sbt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr,
   input  job_type wr_job,
   output logic    full,
   input  logic    rd,
   output logic    valid,
   output job_type rd_job
);

   job_type    slot_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign full   = (count_ff == 2'd2);
   assign valid  = (count_ff != 2'd0);
   assign rd_job = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (wr) slot_ff[wptr_ff] <= wr_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0; rptr_ff <= 1'b0; count_ff <= 2'd0;
      end else begin
         if (wr) wptr_ff <= ~wptr_ff;
         if (rd) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(wr) - 2'(rd);
      end
   end

endmodule

// ----- sv/sbt_back.sv -----
// back end: expands jobs into result words, one per cycle while the output register is empty or popped
`timescale 1ns / 1ps
module sbt_back
   import sbt_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   localparam logic [31:0] BLK = 32'(BLOCK_BYTES);

   logic [5:0] idx_ff, idx_in, len;
   logic       out_v_ff, load, at_end;
   rsp_type    out_ff, word;
   logic [28:0] got;

   assign len     = resp_len_f(job.kind);
   assign at_end  = (idx_ff == len - 6'd1);
   assign load    = job_valid && (!out_v_ff || pop);
   assign job_pop = load && at_end;
   assign idx_in  = at_end ? 6'd0 : idx_ff + 6'd1;
   assign got     = 29'(job.blocks) * 29'(BLOCK_BYTES);

   always_comb begin
      word = '0;
      word.ok = job.ok;
      word.last = at_end;
      if (job.kind != RK_NONE) begin
         word.has_byte  = 1'b1;
         word.resp_byte = resp_byte_f(job.kind, idx_ff, job.key, job.code, job.lba, BLK);
         word.data_len  = 16'(len);
      end else begin
         word.req_write   = job.req_write;
         word.req_read    = job.req_read;
         word.req_lba     = job.lba;
         word.req_count   = job.count;
         word.eject_pulse = job.eject;
         word.data_len    = job.req_read ? got[15:0] : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) out_ff <= word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0; idx_ff <= 6'd0;
      end else begin
         if (load) idx_ff <= idx_in;
         if (load) out_v_ff <= 1'b1;
         else if (pop) out_v_ff <= 1'b0;
      end
   end

   assign empty    = !out_v_ff;
   assign rsp_data = out_ff;

   // mid-stream index only while a streaming job sits at the queue head
   a_idx_stream: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 6'd0 |-> job_valid && job.kind != RK_NONE)
      else $error("stream index without streaming job");
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.has_byte |-> out_ff.ok && !out_ff.req_read && !out_ff.req_write)
      else $error("response byte on a failed or storage word");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !pop |=> out_v_ff && $stable(out_ff))
      else $error("waiting result word changed");
   a_pop_end: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> out_ff.last)
      else $error("job retired without last word");

endmodule

// ----- sv/scsi_block_target_engine.sv -----
// top level of the scsi block target: csr, front end, job queue, back end
`timescale 1ns / 1ps
// Items are taken one per cycle while the two-entry job queue has room; the
// front end updates command state in the accepting cycle. Every item gives
// one result word, except a response-generating read item, which gives one
// word per response byte (4 to 36). The back end issues one word per cycle
// into the output register while it is empty or being popped, and at best
// a result word is on the result ports from the edge after the one that
// takes its item.
// total_blocks lies at address 0 and may be written only while idle.
module scsi_block_target_engine
   import sbt_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0] total_blocks_ff;
   logic        accept, q_valid, q_pop;
   job_type     f_job, q_job;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? total_blocks_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) total_blocks_ff <= '0;
      else if (psel && penable && pwrite && paddr[2] == 1'b0) total_blocks_ff <= pwdata;
   end

   assign accept = push && !full;

   sbt_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
      .clock(clock), .reset(reset), .accept(accept), .req_data(req_data),
      .total_blocks(total_blocks_ff), .job(f_job)
   );

   sbt_queue u_queue (
      .clock(clock), .reset(reset), .wr(accept), .wr_job(f_job), .full(full),
      .rd(q_pop), .valid(q_valid), .rd_job(q_job)
   );

   sbt_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
      .clock(clock), .reset(reset), .job_valid(q_valid), .job(q_job),
      .job_pop(q_pop), .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

endmodule

// ----- bench/scsi_block_target_engine_test.sv -----
// self-checking testbench for the scsi block target engine
`timescale 1ns / 1ps
module scsi_block_target_engine_test;
   import sbt_pkg::*;

   localparam int BLK = 512;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [2:0] ADDR_TOTAL_BLOCKS = 3'd0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   req_type     req_data = '0;
   logic        empty;
   logic        pop = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   scsi_block_target_engine u_dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predicted target state
   logic [31:0] total_blocks;
   logic [7:0]  t_opcode;
   logic [4:0]  t_cdb_len;
   logic [7:0]  t_flags;
   logic [31:0] t_word;
   logic        t_open, t_rx_done, t_tx_done;
   logic [3:0]  t_key;
   logic [7:0]  t_code;
   logic [31:0] t_lba;
   logic [15:0] t_left;

   rsp_type expected_words[$];
   int      errors = 0;
   int      items_sent = 0;
   int      cycles = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_off = 0;

   function automatic rsp_type one_word(logic ok);
      rsp_type w;
      w = '0;
      w.ok = ok;
      w.last = 1'b1;
      return w;
   endfunction

   function automatic void set_illegal();
      t_key = KEY_ILLEGAL;
      t_code = ASC_BAD_OPCODE;
   endfunction

   function automatic void predict_target_words(req_type r);
      rsp_type     w;
      logic [7:0]  rb[36];
      logic [31:0] lastlba, got;
      logic [15:0] blocks;
      logic [4:0]  len;
      logic        ok;
      int          n;
      w = one_word(1'b0);
      case (r.cmd)
         CMD_START: begin
            w.ok = 1'b1;
            if (r.cdb_len == 5'd0) begin
               set_illegal();
               w.ok = 1'b0;
            end else begin
               t_opcode = r.opcode; t_cdb_len = r.cdb_len; t_flags = r.cdb_flags;
               t_word = r.cdb_word;
               t_open = 1'b1; t_rx_done = 1'b0; t_tx_done = 1'b0;
               if (r.opcode == OPC_WR10 || r.opcode == OPC_RD10) begin
                  if (r.cdb_len < 5'd10) w.ok = 1'b0;
                  else begin
                     t_lba = r.cdb_word;
                     t_left = r.cdb_length_field;
                  end
               end
            end
            expected_words.push_back(w);
         end
         CMD_WRITE: begin
            if (!t_open) set_illegal();
            else if (t_rx_done) ;
            else if (t_opcode != OPC_WR10) set_illegal();
            else begin
               blocks = 16'(r.xfer_len / BLK);
               w.ok = r.storage_ok; w.req_write = 1'b1;
               w.req_lba = t_lba; w.req_count = blocks;
               t_lba = t_lba + 32'(blocks);
               t_left = t_left - blocks;
               if (t_left == 16'd0) t_rx_done = 1'b1;
            end
            expected_words.push_back(w);
         end
         CMD_READ: begin
            n = 0;
            if (!t_open) set_illegal();
            else if (t_tx_done) ;
            else if (t_opcode == OPC_RD10) begin
               got = 32'(r.storage_bytes) - 32'(r.storage_bytes) % BLK;
               blocks = 16'(got / BLK);
               w.ok = r.storage_ok; w.req_read = 1'b1;
               w.req_lba = t_lba; w.req_count = t_left; w.data_len = 16'(got);
               t_lba = t_lba + 32'(blocks);
               t_left = t_left - blocks;
               if (t_left == 16'd0) t_tx_done = 1'b1;
            end else begin
               lastlba = total_blocks - 32'd1;
               foreach (rb[i]) rb[i] = 8'h00;
               case (t_opcode)
                  OPC_SENSE: if (r.xfer_len >= 16'd18) begin
                     rb[0] = 8'h70; rb[2] = {4'h0, t_key}; rb[7] = 8'd10;
                     rb[12] = t_code;
                     t_key = '0; t_code = '0;
                     n = 18;
                  end
                  OPC_INQ: if (t_cdb_len >= 5'd5 && r.xfer_len >= 16'd36) begin
                     if (!t_flags[0]) begin
                        if (t_word[31:24] == 8'h00) begin
                           rb[1] = 8'h80; rb[2] = 8'h04; rb[3] = 8'h02; rb[4] = 8'd31;
                           for (int i = 0; i < 28; i++) rb[8 + i] = INQ_IDS[i];
                           n = 36;
                        end
                     end else if (t_word[31:24] == PAGE_SERIAL) begin
                        rb[1] = 8'h80; rb[3] = 8'h01; rb[4] = 8'h30;
                        n = 5;
                     end
                  end
                  OPC_FMTCAP: if (r.xfer_len >= 16'd12) begin
                     rb[3] = 8'd8;
                     {rb[4], rb[5], rb[6], rb[7]} = lastlba;
                     rb[8] = 8'h02;
                     {rb[9], rb[10], rb[11]} = 24'(BLK);
                     n = 12;
                  end
                  OPC_CAP10: if (r.xfer_len >= 16'd8) begin
                     {rb[0], rb[1], rb[2], rb[3]} = lastlba;
                     {rb[4], rb[5], rb[6], rb[7]} = 32'(BLK);
                     n = 8;
                  end
                  OPC_MODE6: if (r.xfer_len >= 16'd4) begin
                     rb[0] = 8'd3;
                     n = 4;
                  end
                  default: set_illegal();
               endcase
               if (n > 0) t_tx_done = 1'b1;
            end
            if (n == 0) expected_words.push_back(w);
            for (int k = 0; k < n; k++) begin
               w = '0;
               w.ok = 1'b1; w.has_byte = 1'b1; w.resp_byte = rb[k];
               w.last = (k == n - 1); w.data_len = 16'(n);
               expected_words.push_back(w);
            end
         end
         default: begin
            if (t_open) begin
               len = t_cdb_len;
               t_open = 1'b0;
               t_cdb_len = '0;
               ok = 1'b0;
               case (t_opcode)
                  OPC_WR10: ok = t_rx_done;
                  OPC_SENSE, OPC_INQ, OPC_FMTCAP, OPC_CAP10, OPC_MODE6, OPC_RD10:
                     ok = t_tx_done;
                  OPC_READY: ok = 1'b1;
                  OPC_REMOVAL: ok = (len >= 5'd6 && t_word[7:0] == 8'h00);
                  OPC_STARTSTOP: if (len >= 5'd6) begin
                     ok = 1'b1;
                     w.eject_pulse = t_word[9];
                  end
                  default: set_illegal();
               endcase
               w.ok = ok;
            end
            expected_words.push_back(w);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic report(string name, logic [31:0] exp_v, logic [31:0] got_v);
      $display("%0t mismatch on %s: expected %h, got %h", $time, name, exp_v, got_v);
      errors++;
   endtask

   // result side: check at the edge, then choose pop for the next cycle
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && pop && !empty) begin
         if (expected_words.size() == 0) begin
            $display("%0t unexpected word, got %h", $time, rsp_data);
            errors++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_data.ok !== e.ok) report("ok", e.ok, rsp_data.ok);
            if (rsp_data.has_byte !== e.has_byte)
               report("has_byte", e.has_byte, rsp_data.has_byte);
            if (rsp_data.resp_byte !== e.resp_byte)
               report("resp_byte", e.resp_byte, rsp_data.resp_byte);
            if (rsp_data.last !== e.last) report("last", e.last, rsp_data.last);
            if (rsp_data.req_write !== e.req_write)
               report("req_write", e.req_write, rsp_data.req_write);
            if (rsp_data.req_read !== e.req_read)
               report("req_read", e.req_read, rsp_data.req_read);
            if (rsp_data.req_lba !== e.req_lba)
               report("req_lba", e.req_lba, rsp_data.req_lba);
            if (rsp_data.req_count !== e.req_count)
               report("req_count", e.req_count, rsp_data.req_count);
            if (rsp_data.eject_pulse !== e.eject_pulse)
               report("eject_pulse", e.eject_pulse, rsp_data.eject_pulse);
            if (rsp_data.data_len !== e.data_len)
               report("data_len", e.data_len, rsp_data.data_len);
         end
      end
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_item(req_type r);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      predict_target_words(r);
      items_sent++;
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_total_blocks(logic [31:0] v);
      wait_drained();
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= ADDR_TOTAL_BLOCKS; pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      total_blocks = v;
   endtask

   function automatic req_type mk(logic [1:0] c, logic [4:0] len, logic [7:0] op,
         logic [7:0] fl, logic [31:0] wd, logic [15:0] lf, logic [15:0] xl,
         logic sok, logic [15:0] sb);
      req_type r;
      r.cmd = c; r.cdb_len = len; r.opcode = op; r.cdb_flags = fl; r.cdb_word = wd;
      r.cdb_length_field = lf; r.xfer_len = xl; r.storage_ok = sok;
      r.storage_bytes = sb;
      return r;
   endfunction

   function automatic req_type noise_item();
      return mk(2'($urandom), 5'($urandom), 8'($urandom), 8'($urandom), $urandom,
                16'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
   endfunction

   task automatic send_start(logic [4:0] len, logic [7:0] op, logic [7:0] fl,
         logic [31:0] wd, logic [15:0] lf);
      send_item(mk(CMD_START, len, op, fl, wd, lf, '0, 1'b0, '0));
   endtask

   task automatic send_end();
      send_item(mk(CMD_END, '0, '0, '0, '0, '0, '0, 1'b0, '0));
   endtask

   task automatic send_read(logic [15:0] cap, logic sok, logic [15:0] sb);
      send_item(mk(CMD_READ, '0, '0, '0, '0, '0, cap, sok, sb));
   endtask

   task automatic send_write(logic [15:0] xl, logic sok);
      send_item(mk(CMD_WRITE, '0, '0, '0, '0, '0, xl, sok, '0));
   endtask

   task automatic test_directed();
      send_start(5'd0, OPC_READY, '0, '0, '0);          // empty command block
      send_end();                                        // nothing open
      send_write(16'd512, 1'b1);
      send_read(16'd64, 1'b1, '0);
      send_start(5'd6, OPC_SENSE, '0, '0, '0);
      send_read(16'd17, 1'b1, '0);                       // buffer too small
      send_read(16'd18, 1'b1, '0);
      send_read(16'd18, 1'b1, '0);                       // phase already done
      send_end();
      send_start(5'd6, OPC_INQ, 8'h00, 32'h0, '0);
      send_read(16'hFFFF, 1'b1, '0);
      send_start(5'd6, OPC_INQ, 8'h01, 32'h8000_0000, '0);
      send_read(16'd36, 1'b1, '0);
      send_start(5'd6, OPC_INQ, 8'h01, 32'h0, '0);       // bad page
      send_read(16'd36, 1'b1, '0);
      send_start(5'd4, OPC_INQ, 8'h00, 32'h0, '0);       // short block
      send_read(16'd36, 1'b1, '0);
      send_start(5'd10, OPC_FMTCAP, '0, '0, '0);
      send_read(16'd12, 1'b1, '0);
      send_start(5'd10, OPC_CAP10, '0, '0, '0);
      send_read(16'd8, 1'b1, '0);
      send_start(5'd6, OPC_MODE6, '0, '0, '0);
      send_read(16'd4, 1'b1, '0);
      send_end();
      send_start(5'd9, OPC_WR10, '0, 32'h1234, 16'd2);   // short write
      send_start(5'd16, OPC_WR10, 8'hFF, 32'hFFFF_FFFF, 16'd2);
      send_write(16'd1024, 1'b0);
      send_write(16'd512, 1'b1);                          // already received
      send_end();
      send_start(5'd31, OPC_RD10, '0, 32'h10, 16'hFFFF);
      send_read('0, 1'b1, 16'hFFFF);
      send_write(16'd512, 1'b1);                          // wrong phase
      send_end();
      send_start(5'd6, OPC_REMOVAL, '0, '0, '0);
      send_end();
      send_start(5'd6, OPC_STARTSTOP, '0, 32'h0000_0200, '0);
      send_end();
      send_start(5'd6, 8'hFF, '0, '0, '0);                // unknown opcode
      send_end();
   endtask

   task automatic random_transaction();
      logic [7:0]  ops[11];
      logic [7:0]  op;
      logic [4:0]  len;
      logic [15:0] cnt;
      int          k;
      ops = '{OPC_READY, OPC_SENSE, OPC_INQ, OPC_FMTCAP, OPC_CAP10, OPC_MODE6,
              OPC_RD10, OPC_REMOVAL, OPC_STARTSTOP, OPC_WR10, 8'($urandom)};
      op = ops[$urandom_range(0, 10)];
      len = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(10, 16));
      cnt = 16'($urandom_range(1, 4));
      send_item(mk(CMD_START, len, op, 8'($urandom_range(0, 1)),
                   {($urandom_range(0, 1) ? PAGE_SERIAL : 8'h00),
                    16'($urandom), ($urandom_range(0, 1) ? 8'h00 : 8'($urandom))},
                   cnt, 16'($urandom), 1'($urandom), 16'($urandom)));
      k = $urandom_range(1, 3);
      for (int i = 0; i < k; i++) begin
         if (op == OPC_WR10)
            send_write(16'($urandom_range(0, 3) * BLK + $urandom_range(0, 3)),
                       1'($urandom));
         else if (op == OPC_RD10)
            send_read(16'($urandom), 1'($urandom),
                      16'($urandom_range(0, 3) * BLK + $urandom_range(0, 511)));
         else
            send_read(16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 40)
                                                    : $urandom_range(36, 65535)),
                      1'($urandom), 16'($urandom));
      end
      if ($urandom_range(0, 9) != 0) send_end();
   endtask

   task automatic test_random(int n);
      int target;
      target = items_sent + n;
      while (items_sent < target) begin
         if ($urandom_range(0, 99) < 80) random_transaction();
         else send_item(noise_item());
      end
   endtask

   task automatic test_full_stall();
      hold_off = 300;
      for (int i = 0; i < 6; i++) begin
         send_start(5'd6, OPC_INQ, 8'h00, 32'h0, '0);
         send_read(16'd36, 1'b1, '0);
      end
      send_end();
      wait_drained();                                      // sender pauses here
   endtask

   initial begin
      total_blocks = '0;
      t_opcode = '0; t_cdb_len = '0; t_flags = '0; t_word = '0;
      t_open = 1'b0; t_rx_done = 1'b0; t_tx_done = 1'b0;
      t_key = '0; t_code = '0; t_lba = '0; t_left = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_total_blocks(32'd1);
      test_directed();
      write_total_blocks(32'hFFFF_FFFF);
      send_idle_pct = 7; recv_idle_pct = 63;
      test_random(100);
      test_full_stall();
      write_total_blocks($urandom);
      send_idle_pct = 63; recv_idle_pct = 7;
      test_random(100);
      write_total_blocks(32'd0);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(40);
      write_total_blocks($urandom);
      test_random(40);
      wait_drained();
      if (errors == 0 && expected_words.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
